### sv/cdtc_pkg.sv
// ----------------------------------------------------------------------------
// cdtc_pkg
// Shared widths and types for the critically damped target chase.
// ----------------------------------------------------------------------------
package cdtc_pkg;

    localparam int SPEED_W     = 32;
    localparam int STEP_TIME_W = 16;
    localparam int RATE_W      = 40;
    localparam int COEF_W      = 32;

    localparam int MUL_MAG_W = 62;
    localparam int MUL_OP_W  = COEF_W;
    localparam int STEPS_W   = $clog2(MUL_OP_W + 1);

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

### sv/critically_damped_target_chase.sv
// ----------------------------------------------------------------------------
// critically_damped_target_chase
// Second-order critically damped smoothing of a target speed.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries a Q0.16 step time and a
// signed Q16.16 target speed; output channel (o_out_valid / i_out_ready)
// returns one smoothed speed per input transfer. Coefficients and the enable
// are to be loaded through the write port only while no item is in flight;
// the block itself does not enforce this. Pass-through items (disabled,
// negative target, first target after disarm) go from the idle state straight
// to the finish state, which raises o_out_valid. A chase step first runs the
// prep, multiply, accel, rate and value states: one shared bit-serial
// multiplier forms the omega-squared product at full width (a second unit
// forms the two-omega product alongside), then the rate and value updates at
// step-time width. One item is processed at a time; the next is taken once
// the result sits in the output register, so an item can be accepted while a
// result still waits. A stalled receiver holds the result in the output
// register and the block waits before writing the next one.
// Reset clears the state, the output valid, the coefficients, the enable and the chase state (disarmed).
// ----------------------------------------------------------------------------
module critically_damped_target_chase (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [1:0]                          i_cfg_index,
    input  logic [cdtc_pkg::COEF_W-1:0]         i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [cdtc_pkg::STEP_TIME_W-1:0]    i_step_time,
    input  logic signed [cdtc_pkg::SPEED_W-1:0] i_target_speed,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [cdtc_pkg::SPEED_W-1:0] o_smoothed_speed
);
    import cdtc_pkg::*;

    typedef enum logic [1:0] {
        CFG_CHASE_ENABLED = 2'd0,
        CFG_OMEGA_SQUARED = 2'd1,
        CFG_TWO_OMEGA     = 2'd2
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_AB,
        ST_ACCEL,
        ST_RATE_START,
        ST_RATE_MUL,
        ST_RATE,
        ST_VALUE_START,
        ST_VALUE_MUL,
        ST_VALUE,
        ST_FINISH
    } t_state;

    localparam int LIM_W  = MUL_MAG_W;
    localparam int TERM_W = LIM_W + 1;
    localparam int ACC_W  = TERM_W + 1;
    localparam int PA_W   = MUL_MAG_W + MUL_OP_W;
    localparam int PB_W   = RATE_W + MUL_OP_W;
    localparam int OSQ_SH = 8;
    localparam int TWO_SH = 16;
    localparam int DT_SH  = 16;
    localparam int SA_W   = PA_W - OSQ_SH;

    localparam logic [LIM_W-1:0] PROD_LIM = {1'b1, {(LIM_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_HI = $signed(ACC_W'(PROD_LIM));
    localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI;
    localparam logic signed [ACC_W-1:0] RATE_HI = ACC_W'({1'b0, {(RATE_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] RATE_LO = -RATE_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] VAL_HI = ACC_W'({1'b0, {(SPEED_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] VAL_LO = -VAL_HI - ACC_W'(1);
    localparam logic [STEPS_W-1:0] FULL_STEPS = STEPS_W'(MUL_OP_W);
    localparam logic [STEPS_W-1:0] DT_STEPS   = STEPS_W'(STEP_TIME_W);

    function automatic logic signed [TERM_W-1:0] signed_term(
        input logic [SA_W-1:0] mag,
        input logic            neg
    );
        logic [LIM_W-1:0] m;
        m = (mag > SA_W'(PROD_LIM)) ? PROD_LIM : mag[LIM_W-1:0];
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    t_state                      r_state;
    logic                        r_chase_enabled;
    logic [COEF_W-1:0]           r_omega_sq;
    logic [COEF_W-1:0]           r_two_omega;
    logic                        r_engaged;
    logic signed [SPEED_W-1:0]   r_value;
    logic signed [RATE_W-1:0]    r_rate;
    logic [STEP_TIME_W-1:0]      r_dt;
    logic signed [SPEED_W:0]     r_diff;
    logic signed [TERM_W-1:0]    r_term_a;
    logic signed [TERM_W-1:0]    r_term_b;
    logic signed [TERM_W-1:0]    r_accel;
    logic                        r_neg_a;
    logic                        r_neg_b;
    logic signed [SPEED_W-1:0]   r_res;
    logic                        r_out_valid;
    logic signed [SPEED_W-1:0]   r_out_data;

    logic signed [SPEED_W:0]     n_diff;
    logic [SPEED_W:0]            abs_diff;
    logic signed [RATE_W:0]      rate_x;
    logic [RATE_W-1:0]           abs_rate;
    logic [LIM_W-1:0]            abs_accel;
    logic signed [ACC_W-1:0]     accel_sum;
    logic signed [ACC_W-1:0]     rate_sum;
    logic signed [ACC_W-1:0]     value_sum;
    logic signed [TERM_W-1:0]    n_accel;
    logic signed [RATE_W-1:0]    n_rate;
    logic signed [SPEED_W-1:0]   n_value;

    logic                        mul_a_start;
    logic [STEPS_W-1:0]          mul_a_steps;
    logic [MUL_MAG_W-1:0]        mul_a_mag;
    logic [MUL_OP_W-1:0]         mul_a_op;
    logic                        mul_b_start;
    t_mul_stat                   stat_a;
    t_mul_stat                   stat_b;
    logic [PA_W-1:0]             prod_a;
    logic [PB_W-1:0]             prod_b;
    logic [SA_W-1:0]             prod_osq;
    logic [SA_W-1:0]             prod_dt;
    logic [SA_W-1:0]             prod_two;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chase_enabled <= 1'b0;
            r_omega_sq      <= '0;
            r_two_omega     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CHASE_ENABLED: r_chase_enabled <= i_cfg_wdata[0];
                CFG_OMEGA_SQUARED: r_omega_sq      <= i_cfg_wdata;
                CFG_TWO_OMEGA:     r_two_omega     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign n_diff    = (SPEED_W+1)'(i_target_speed) - (SPEED_W+1)'(r_value);
    assign abs_diff  = r_diff[SPEED_W] ? (SPEED_W+1)'(-r_diff) : (SPEED_W+1)'(r_diff);
    assign rate_x    = (RATE_W+1)'(r_rate);
    assign abs_rate  = RATE_W'((rate_x < 0) ? -rate_x : rate_x);
    assign abs_accel = r_accel[TERM_W-1] ? LIM_W'(-r_accel) : LIM_W'(r_accel);

    assign accel_sum = ACC_W'(r_term_a) - ACC_W'(r_term_b);
    assign rate_sum  = ACC_W'(r_rate) + ACC_W'(r_term_a);
    assign value_sum = ACC_W'(r_value) + ACC_W'(r_term_a);

    always_comb begin
        if (accel_sum > ACC_HI) begin
            n_accel = TERM_W'(ACC_HI);
        end else if (accel_sum < ACC_LO) begin
            n_accel = TERM_W'(ACC_LO);
        end else begin
            n_accel = TERM_W'(accel_sum);
        end
        if (rate_sum > RATE_HI) begin
            n_rate = RATE_W'(RATE_HI);
        end else if (rate_sum < RATE_LO) begin
            n_rate = RATE_W'(RATE_LO);
        end else begin
            n_rate = RATE_W'(rate_sum);
        end
        if (value_sum > VAL_HI) begin
            n_value = SPEED_W'(VAL_HI);
        end else if (value_sum < VAL_LO) begin
            n_value = SPEED_W'(VAL_LO);
        end else begin
            n_value = SPEED_W'(value_sum);
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a_start = 1'b0;
        mul_a_steps = FULL_STEPS;
        mul_a_mag   = '0;
        mul_a_op    = '0;
        mul_b_start = 1'b0;
        unique case (r_state)
            ST_PREP: begin
                mul_a_start = 1'b1;
                mul_a_mag   = MUL_MAG_W'(abs_diff);
                mul_a_op    = r_omega_sq;
                mul_b_start = 1'b1;
            end
            ST_RATE_START: begin
                mul_a_start = 1'b1;
                mul_a_steps = DT_STEPS;
                mul_a_mag   = abs_accel;
                mul_a_op    = MUL_OP_W'(r_dt);
            end
            ST_VALUE_START: begin
                mul_a_start = 1'b1;
                mul_a_steps = DT_STEPS;
                mul_a_mag   = MUL_MAG_W'(abs_rate);
                mul_a_op    = MUL_OP_W'(r_dt);
            end
            default: ;
        endcase
    end

    cdtc_serial_mul #(
        .MAG_W (MUL_MAG_W),
        .MUL_W (MUL_OP_W)
    ) u_mul_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_a_start),
        .i_steps (mul_a_steps),
        .i_mag   (mul_a_mag),
        .i_mul   (mul_a_op),
        .o_stat  (stat_a),
        .o_prod  (prod_a)
    );

    cdtc_serial_mul #(
        .MAG_W (RATE_W),
        .MUL_W (MUL_OP_W)
    ) u_mul_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_b_start),
        .i_steps (FULL_STEPS),
        .i_mag   (abs_rate),
        .i_mul   (r_two_omega),
        .o_stat  (stat_b),
        .o_prod  (prod_b)
    );

    assign prod_osq = SA_W'(prod_a >> OSQ_SH);
    assign prod_dt  = SA_W'(prod_a >> (MUL_OP_W - STEP_TIME_W + DT_SH));
    assign prod_two = SA_W'(prod_b >> TWO_SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_engaged   <= 1'b0;
            r_value     <= '0;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_dt   <= i_step_time;
                        r_res  <= i_target_speed;
                        r_diff <= n_diff;
                        if (!r_chase_enabled) begin
                            r_state <= ST_FINISH;
                        end else if (i_target_speed < 0) begin
                            r_engaged <= 1'b0;
                            r_value   <= '0;
                            r_rate    <= '0;
                            r_state   <= ST_FINISH;
                        end else if (!r_engaged) begin
                            r_engaged <= 1'b1;
                            r_value   <= i_target_speed;
                            r_rate    <= '0;
                            r_state   <= ST_FINISH;
                        end else begin
                            r_state <= ST_PREP;
                        end
                    end
                end
                ST_PREP: begin
                    r_neg_a <= r_diff[SPEED_W];
                    r_neg_b <= r_rate[RATE_W-1];
                    r_state <= ST_MUL_AB;
                end
                ST_MUL_AB: begin
                    if (stat_a.done) begin
                        r_term_a <= signed_term(prod_osq, r_neg_a);
                        r_term_b <= signed_term(prod_two, r_neg_b);
                        r_state  <= ST_ACCEL;
                    end
                end
                ST_ACCEL: begin
                    r_accel <= n_accel;
                    r_state <= ST_RATE_START;
                end
                ST_RATE_START: begin
                    r_neg_a <= r_accel[TERM_W-1];
                    r_state <= ST_RATE_MUL;
                end
                ST_RATE_MUL: begin
                    if (stat_a.done) begin
                        r_term_a <= signed_term(prod_dt, r_neg_a);
                        r_state  <= ST_RATE;
                    end
                end
                ST_RATE: begin
                    r_rate  <= n_rate;
                    r_state <= ST_VALUE_START;
                end
                ST_VALUE_START: begin
                    r_neg_a <= r_rate[RATE_W-1];
                    r_state <= ST_VALUE_MUL;
                end
                ST_VALUE_MUL: begin
                    if (stat_a.done) begin
                        r_term_a <= signed_term(prod_dt, r_neg_a);
                        r_state  <= ST_VALUE;
                    end
                end
                ST_VALUE: begin
                    r_value <= n_value;
                    r_res   <= n_value;
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_smoothed_speed = r_out_data;

`ifndef SYNTHESIS
    a_disarmed_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_engaged |-> (r_rate == '0))
        else $error("rate not clear while disarmed");

    a_mul_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL_AB) |-> (stat_a.done == stat_b.done))
        else $error("coefficient products out of step");

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_a_start |-> !stat_a.busy)
        else $error("multiplier restarted while busy");

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !r_chase_enabled) |=> (r_state == ST_FINISH))
        else $error("disabled transfer not passed straight through");
`endif

endmodule

### sv/cdtc_serial_mul.sv
// ----------------------------------------------------------------------------
// cdtc_serial_mul
// Bit-serial shift-add magnitude multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cdtc_serial_mul #(
    parameter int MAG_W = cdtc_pkg::MUL_MAG_W,
    parameter int MUL_W = cdtc_pkg::MUL_OP_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [$clog2(MUL_W + 1)-1:0]   i_steps,
    input  logic [MAG_W-1:0]               i_mag,
    input  logic [MUL_W-1:0]               i_mul,
    output cdtc_pkg::t_mul_stat            o_stat,
    output logic [MAG_W+MUL_W-1:0]         o_prod
);
    import cdtc_pkg::*;

    localparam int CNT_W = $clog2(MUL_W + 1);

    logic [MAG_W-1:0] r_acc;
    logic [MUL_W-1:0] r_q;
    logic [MAG_W-1:0] r_mag;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [MAG_W:0]   n_sum;

    assign n_sum = {1'b0, r_acc} + (r_q[0] ? {1'b0, r_mag} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_acc  <= '0;
            r_q    <= i_mul;
            r_mag  <= i_mag;
            r_cnt  <= i_steps;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_acc <= n_sum[MAG_W:1];
            r_q   <= {n_sum[0], r_q[MUL_W-1:1]};
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_comb begin
        o_stat      = '0;
        o_stat.busy = r_busy;
        o_stat.done = r_done;
    end

    assign o_prod = {r_acc, r_q};

endmodule
